// ===== hdl/wkbp_pkg.sv =====
// Package for the WKB geometry vertex parser: parser phase codes, result kinds,
// error codes, geometry type codes and the result word type.
// No dependencies; the parser top, the decoder and the output stage import it.
package wkbp_pkg;

  // Parser phases.
  localparam logic [2:0] PH_ORDER    = 3'd0;
  localparam logic [2:0] PH_TYPE     = 3'd1;
  localparam logic [2:0] PH_NPOINTS  = 3'd2;
  localparam logic [2:0] PH_NRINGS   = 3'd3;
  localparam logic [2:0] PH_NMEMBERS = 3'd4;
  localparam logic [2:0] PH_X        = 3'd5;
  localparam logic [2:0] PH_Y        = 3'd6;
  localparam logic [2:0] PH_IDLE     = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BYTE_ORDER = 3'd1;
  localparam logic [2:0] ERR_BAD_TYPE   = 3'd2;
  localparam logic [2:0] ERR_COLLECTION = 3'd3;
  localparam logic [2:0] ERR_NESTED     = 3'd4;

  // Geometry type codes.
  localparam logic [31:0] GT_POINT      = 32'd1;
  localparam logic [31:0] GT_POLYGON    = 32'd3;
  localparam logic [31:0] GT_MULTIPOINT = 32'd4;
  localparam logic [31:0] GT_MULTIPOLY  = 32'd6;
  localparam logic [31:0] GT_COLLECTION = 32'd7;
  localparam logic [31:0] GT_LINE       = 32'd2;

  // Byte-order byte values.
  localparam logic [7:0] BO_BIG    = 8'd0;
  localparam logic [7:0] BO_LITTLE = 8'd1;

  // Last byte index of 32-bit and 64-bit fields.
  localparam logic [2:0] LAST_IDX_32 = 3'd3;
  localparam logic [2:0] LAST_IDX_64 = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic        new_part;
    logic        record_done;
    logic [2:0]  error_code;
  } wkbp_res_t;

endpackage

// ===== hdl/wkbp_if.sv =====
// Valid/ready channel interfaces for the WKB geometry vertex parser:
// the byte input channel and the result output channel. No dependencies.
interface wkbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface wkbp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] x_bits;
  logic [63:0] y_bits;
  logic        new_part;
  logic        record_done;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output x_bits, output y_bits,
                  output new_part, output record_done, output error_code, input ready);
  modport sink   (input valid, input kind, input x_bits, input y_bits,
                  input new_part, input record_done, input error_code, output ready);
endinterface

// ===== hdl/wkb_geometry_vertex_parser.sv =====
// Top level of the WKB geometry vertex parser: byte decoder plus result register.
// Depends on wkbp_pkg, wkbp_if, wkbp_decoder and wkbp_out_stage.

// The parser takes a well-known-binary geometry record one byte per word on
// in_i and gives at most one result word per byte on out_o: a 2D vertex as raw
// 64-bit double patterns (new_part marks the first vertex of each point, line or
// ring), an empty part, a bare record end, or an error that stops the record.
// Every byte is decoded in the cycle it is accepted and its result is written to
// a single output register, so the block sustains one byte per clock; a byte is
// accepted whenever the output register is empty or its word is taken in that
// same cycle, and a result appears on out_o the cycle after its byte. A byte with
// record_start high restarts the parser; after an error or the end of a record,
// bytes are taken and dropped until the next record start. Coordinates are
// delivered in host bit order whatever the byte order of the record, and a vertex
// whose x and y patterns equal those of the one kept just before it in the same
// line or ring is dropped. Multi geometries nest one level deep only.
module wkb_geometry_vertex_parser
  import wkbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  wkbp_in_if.sink           in_i,
  wkbp_out_if.source        out_o
);

  logic      step;
  logic      can_load;
  logic      res_valid;
  wkbp_res_t res;
  wkbp_res_t out_res;

  assign in_i.ready = can_load;
  assign step       = in_i.valid && can_load;

  wkbp_decoder u_decoder (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (in_i.data_byte),
    .record_start_i (in_i.record_start),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  wkbp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .can_load_o  (can_load),
    .out_valid_o (out_o.valid),
    .out_res_o   (out_res)
  );

  assign out_o.kind        = out_res.kind;
  assign out_o.x_bits      = out_res.x_bits;
  assign out_o.y_bits      = out_res.y_bits;
  assign out_o.new_part    = out_res.new_part;
  assign out_o.record_done = out_res.record_done;
  assign out_o.error_code  = out_res.error_code;

  // Only vertices carry coordinates and a part mark.
  a_non_vertex_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != KIND_VERTEX) |->
      (out_o.x_bits == '0 && out_o.y_bits == '0 && !out_o.new_part))
    else $error("non-vertex result carries coordinates");

  // Errors always close the record with a nonzero code; others carry no code.
  a_error_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      ((out_o.kind == KIND_ERROR) ? (out_o.record_done && out_o.error_code != ERR_NONE)
                                  : (out_o.error_code == ERR_NONE)))
    else $error("error code does not match result kind");

  // A bare record end is always the last word of its record.
  a_end_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_END) |-> out_o.record_done)
    else $error("record end without record_done");

  // A stalled result blocks the input side.
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while result is stalled");

endmodule

// ===== hdl/wkbp_decoder.sv =====
// Byte decoder of the WKB geometry vertex parser: parser state, field assembly,
// counters and duplicate vertex compare. Depends on wkbp_pkg.
module wkbp_decoder
  import wkbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       record_start_i,
  output logic       res_valid_o,
  output wkbp_res_t  res_o
);

  logic [2:0]  phase_q, phase_d, c_phase;
  logic [2:0]  idx_q, idx_d, c_idx;
  logic [63:0] asm_q, asm_d, c_asm, asm_n;
  logic        obe_q, obe_d, c_obe;
  logic        ibe_q, ibe_d, c_ibe;
  logic [2:0]  gtype_q, gtype_d, c_gtype;
  logic        multi_q, multi_d, c_multi;
  logic [31:0] members_q, members_d, c_members;
  logic [31:0] rings_q, rings_d, c_rings;
  logic [31:0] points_q, points_d, c_points;
  logic        have_prev_q, have_prev_d, c_have_prev;
  logic [63:0] held_x_q, held_x_d;
  logic [63:0] prev_x_q, prev_x_d;
  logic [63:0] prev_y_q, prev_y_d;

  logic        big;
  logic        last;
  logic [31:0] t;
  logic        eg_more;
  logic        el_more;
  logic        dup;
  logic        fin;

  // A record start clears the parser before its byte is decoded.
  always_comb begin
    if (record_start_i) begin
      c_phase     = PH_ORDER;
      c_idx       = '0;
      c_asm       = '0;
      c_obe       = 1'b0;
      c_ibe       = 1'b0;
      c_gtype     = '0;
      c_multi     = 1'b0;
      c_members   = '0;
      c_rings     = '0;
      c_points    = '0;
      c_have_prev = 1'b0;
    end else begin
      c_phase     = phase_q;
      c_idx       = idx_q;
      c_asm       = asm_q;
      c_obe       = obe_q;
      c_ibe       = ibe_q;
      c_gtype     = gtype_q;
      c_multi     = multi_q;
      c_members   = members_q;
      c_rings     = rings_q;
      c_points    = points_q;
      c_have_prev = have_prev_q;
    end
  end

  assign big     = c_multi ? c_ibe : c_obe;
  assign asm_n   = big ? {c_asm[55:0], data_byte_i}
                       : (c_asm | (64'(data_byte_i) << {c_idx, 3'b000}));
  assign last    = (c_phase == PH_X || c_phase == PH_Y) ? (c_idx == LAST_IDX_64)
                                                        : (c_idx == LAST_IDX_32);
  assign t       = asm_n[31:0];
  assign eg_more = c_multi && (c_members > 32'd1);
  assign el_more = (c_gtype == GT_POLYGON[2:0]) && (c_rings > 32'd1);
  assign dup     = c_have_prev && (held_x_q == prev_x_q) && (asm_n == prev_y_q);

  always_comb begin
    phase_d     = c_phase;
    idx_d       = c_idx;
    asm_d       = c_asm;
    obe_d       = c_obe;
    ibe_d       = c_ibe;
    gtype_d     = c_gtype;
    multi_d     = c_multi;
    members_d   = c_members;
    rings_d     = c_rings;
    points_d    = c_points;
    have_prev_d = c_have_prev;
    held_x_d    = held_x_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    fin         = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (c_phase == PH_IDLE) begin
      // Ignore bytes until the next record start.
    end else if (c_phase == PH_ORDER) begin
      if (data_byte_i != BO_BIG && data_byte_i != BO_LITTLE) begin
        phase_d           = PH_IDLE;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_ERROR;
        res_o.record_done = 1'b1;
        res_o.error_code  = ERR_BYTE_ORDER;
      end else begin
        if (c_multi) begin
          ibe_d = (data_byte_i == BO_BIG);
        end else begin
          obe_d = (data_byte_i == BO_BIG);
        end
        phase_d = PH_TYPE;
        idx_d   = '0;
        asm_d   = '0;
      end
    end else if (!last) begin
      asm_d = asm_n;
      idx_d = c_idx + 3'd1;
    end else begin
      asm_d = '0;
      idx_d = '0;
      unique case (c_phase)
        PH_TYPE: begin
          if (t == GT_COLLECTION || t < GT_POINT || t > GT_MULTIPOLY ||
              (t >= GT_MULTIPOINT && c_multi)) begin
            phase_d           = PH_IDLE;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_ERROR;
            res_o.record_done = 1'b1;
            if (t == GT_COLLECTION) begin
              res_o.error_code = ERR_COLLECTION;
            end else if (t < GT_POINT || t > GT_MULTIPOLY) begin
              res_o.error_code = ERR_BAD_TYPE;
            end else begin
              res_o.error_code = ERR_NESTED;
            end
          end else begin
            gtype_d = t[2:0];
            if (t == GT_POINT) begin
              have_prev_d = 1'b0;
              phase_d     = PH_X;
            end else if (t == GT_LINE) begin
              phase_d = PH_NPOINTS;
            end else if (t == GT_POLYGON) begin
              phase_d = PH_NRINGS;
            end else begin
              phase_d = PH_NMEMBERS;
            end
          end
        end
        PH_NRINGS: begin
          if (asm_n == '0) begin
            if (eg_more) begin
              members_d = c_members - 32'd1;
              phase_d   = PH_ORDER;
            end else begin
              members_d = '0;
              phase_d   = PH_IDLE;
              fin       = 1'b1;
            end
          end else begin
            rings_d = asm_n[31:0];
            phase_d = PH_NPOINTS;
          end
        end
        PH_NMEMBERS: begin
          if (asm_n == '0) begin
            phase_d = PH_IDLE;
            fin     = 1'b1;
          end else begin
            members_d = asm_n[31:0];
            multi_d   = 1'b1;
            phase_d   = PH_ORDER;
          end
        end
        PH_NPOINTS: begin
          if (asm_n == '0) begin
            if (el_more) begin
              rings_d = c_rings - 32'd1;
              phase_d = PH_NPOINTS;
            end else begin
              rings_d = '0;
              if (eg_more) begin
                members_d = c_members - 32'd1;
                phase_d   = PH_ORDER;
              end else begin
                members_d = '0;
                phase_d   = PH_IDLE;
                fin       = 1'b1;
              end
            end
            // An empty line or ring reports itself, even when it ends the record.
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_EMPTY;
            res_o.record_done = fin;
          end else begin
            points_d    = asm_n[31:0];
            have_prev_d = 1'b0;
            phase_d     = PH_X;
          end
        end
        PH_X: begin
          held_x_d = asm_n;
          phase_d  = PH_Y;
        end
        PH_Y: begin
          if (!dup) begin
            prev_x_d    = held_x_q;
            prev_y_d    = asm_n;
            have_prev_d = 1'b1;
          end
          if (c_gtype == GT_POINT[2:0] || !(c_points > 32'd1)) begin
            if (c_gtype != GT_POINT[2:0]) begin
              points_d = '0;
            end
            if (c_gtype != GT_POINT[2:0] && el_more) begin
              rings_d = c_rings - 32'd1;
              phase_d = PH_NPOINTS;
            end else begin
              if (c_gtype != GT_POINT[2:0]) begin
                rings_d = '0;
              end
              if (eg_more) begin
                members_d = c_members - 32'd1;
                phase_d   = PH_ORDER;
              end else begin
                members_d = '0;
                phase_d   = PH_IDLE;
                fin       = 1'b1;
              end
            end
          end else begin
            points_d = c_points - 32'd1;
            phase_d  = PH_X;
          end
          if (!dup) begin
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_VERTEX;
            res_o.x_bits      = held_x_q;
            res_o.y_bits      = asm_n;
            res_o.new_part    = !c_have_prev;
            res_o.record_done = fin;
          end
        end
        default: begin
        end
      endcase
      // A record that ends without an item of its own gets an end marker.
      if (fin && !res_valid_o) begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_END;
        res_o.record_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ORDER;
      idx_q       <= '0;
      asm_q       <= '0;
      obe_q       <= 1'b0;
      ibe_q       <= 1'b0;
      gtype_q     <= '0;
      multi_q     <= 1'b0;
      members_q   <= '0;
      rings_q     <= '0;
      points_q    <= '0;
      have_prev_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      asm_q       <= asm_d;
      obe_q       <= obe_d;
      ibe_q       <= ibe_d;
      gtype_q     <= gtype_d;
      multi_q     <= multi_d;
      members_q   <= members_d;
      rings_q     <= rings_d;
      points_q    <= points_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      held_x_q <= held_x_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
    end
  end

endmodule

// ===== hdl/wkbp_out_stage.sv =====
// Result register of the WKB geometry vertex parser: holds one result word
// until the sink takes it. Depends on wkbp_pkg.
module wkbp_out_stage
  import wkbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  logic      res_valid_i,
  input  wkbp_res_t res_i,
  input  logic      out_ready_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  output wkbp_res_t out_res_o
);

  logic      valid_q;
  wkbp_res_t res_q;

  // The register frees up in the same cycle its word is taken.
  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule
